### sv/linear_adsr_envelope_vca_core_defines.svh
// Assertion macros shared by the envelope core.
`ifndef LINEAR_ADSR_ENVELOPE_VCA_CORE_DEFINES_SVH
`define LINEAR_ADSR_ENVELOPE_VCA_CORE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define ADSR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ADSR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define ADSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

  // Fixed payload widths
  localparam int SAMPLE_BITS   = 16;
  localparam int LEVEL_BITS    = 16;
  localparam int TIME_BITS_DEF = 20;

  // Unity gain in Q1.15
  localparam logic [LEVEL_BITS-1:0] UNITY = 16'h8000;

  // Envelope phase codes as seen on the result beat
  localparam logic [2:0] PH_OFF     = 3'd0;
  localparam logic [2:0] PH_ATTACK  = 3'd1;
  localparam logic [2:0] PH_DECAY   = 3'd2;
  localparam logic [2:0] PH_SUSTAIN = 3'd3;
  localparam logic [2:0] PH_RELEASE = 3'd4;

  // Configuration register indexes
  localparam int REG_IDX_BITS = 3;
  localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_SAMPLES  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_PEAK     = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_DECAY_SAMPLES   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SUSTAIN_LEVEL   = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_SAMPLES = 3'd4;

  // Register reset values
  localparam int ATTACK_SAMPLES_RST  = 480;
  localparam int DECAY_SAMPLES_RST   = 4800;
  localparam int RELEASE_SAMPLES_RST = 24000;
  localparam logic [LEVEL_BITS-1:0] ATTACK_PEAK_RST   = 16'd32768;
  localparam logic [LEVEL_BITS-1:0] SUSTAIN_LEVEL_RST = 16'd16384;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          gate;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic [LEVEL_BITS-1:0]         envelope_level;
    logic [2:0]                    phase;
  } out_beat_t;

  // Limit a programmed level to unity
  function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [LEVEL_BITS-1:0] v);
    return (v > UNITY) ? UNITY : v;
  endfunction

endpackage

`default_nettype wire

### sv/linear_adsr_envelope_vca_core.sv
`default_nettype none
// Linear ADSR envelope with a stereo VCA. Each input beat carries a stereo
// sample pair and a gate bit; the envelope (off, attack, decay, sustain,
// release) advances once per beat and one result beat returns both samples
// scaled by the new level, floor((level * sample) / 32768), together with
// the level and phase. A rising gate restarts attack from the current
// level, a falling gate starts release from the current level. Phase
// lengths are in samples; converting from time is up to software. Beats
// that run an attack, decay or release ramp pass through an evaluate step,
// then one multiplier computes the two interpolation terms, a restoring
// divider produces one quotient bit per cycle for all 16 quotient bits, and
// the same multiplier then scales left and right. Beats in off or sustain,
// at a phase end or in a zero-length phase skip the ramp and go from the
// evaluate step straight to scaling left and right. The block takes one
// beat at a time; a finished result waits in the output register while the
// next beat is accepted. Write configuration only while no beat is in
// flight; the block does not hold back writes.
`include "linear_adsr_envelope_vca_core_defines.svh"

module linear_adsr_envelope_vca_core #(
  parameter int TIME_BITS = adsr_pkg::TIME_BITS_DEF,
  localparam int CFG_W = (TIME_BITS > adsr_pkg::LEVEL_BITS) ? TIME_BITS
                                                             : adsr_pkg::LEVEL_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire adsr_pkg::in_beat_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      adsr_pkg::out_beat_t                 out_data,
  input  wire logic                                cfg_we,
  input  wire logic [adsr_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]                    cfg_data
);
  import adsr_pkg::*;

  localparam int ELAP_W = TIME_BITS + 1;
  localparam int ACC_W  = TIME_BITS + LEVEL_BITS;
  localparam int MA_W   = ((SAMPLE_BITS > TIME_BITS) ? SAMPLE_BITS : TIME_BITS) + 1;
  localparam int MB_W   = LEVEL_BITS + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int CNT_W  = $clog2(LEVEL_BITS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EVAL  = 7'b0000010,
    S_MUL_A = 7'b0000100,
    S_MUL_B = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_MUL_L = 7'b0100000,
    S_MUL_R = 7'b1000000
  } state_t;

  state_t state;

  // Configuration registers
  logic [TIME_BITS-1:0]  attack_samples;
  logic [LEVEL_BITS-1:0] attack_peak;
  logic [TIME_BITS-1:0]  decay_samples;
  logic [LEVEL_BITS-1:0] sustain_level;
  logic [TIME_BITS-1:0]  release_samples;

  // Envelope state
  logic [2:0]            phase_reg;
  logic [ELAP_W-1:0]     elapsed_count;
  logic [LEVEL_BITS-1:0] level_reg;
  logic [LEVEL_BITS-1:0] attack_origin;
  logic [LEVEL_BITS-1:0] release_origin;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] left_smp;
  logic signed [SAMPLE_BITS-1:0] right_smp;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic [ACC_W-1:0]              acc;
  logic [TIME_BITS-1:0]          rem;
  logic [LEVEL_BITS-1:0]         quo;
  logic [CNT_W-1:0]              div_cnt;

  logic                          in_accept;
  logic [LEVEL_BITS-1:0]         peak;
  logic [LEVEL_BITS-1:0]         sus;
  logic [TIME_BITS-1:0]          cur_len;
  logic [LEVEL_BITS-1:0]         from_level;
  logic [LEVEL_BITS-1:0]         to_level;
  logic [2:0]                    end_phase;
  logic                          is_ramp;
  logic                          past_end;
  logic [TIME_BITS-1:0]          elapsed_t;
  logic signed [MA_W-1:0]        mul_a;
  logic [LEVEL_BITS-1:0]         mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [SAMPLE_BITS-1:0] scaled;
  logic [ACC_W-1:0]              acc_sum;
  logic [TIME_BITS:0]            trial;
  logic [TIME_BITS:0]            trial_diff;
  logic                          trial_ge;
  logic [LEVEL_BITS-1:0]         quo_next;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign peak      = clamp_level(attack_peak);
  assign sus       = clamp_level(sustain_level);
  assign elapsed_t = elapsed_count[TIME_BITS-1:0];

  // Select length, ramp end points and successor for the current phase
  always_comb begin
    cur_len    = '0;
    from_level = '0;
    to_level   = '0;
    end_phase  = phase_reg;
    is_ramp    = 1'b0;
    unique case (phase_reg)
      PH_ATTACK: begin
        cur_len    = attack_samples;
        from_level = attack_origin;
        to_level   = peak;
        end_phase  = PH_DECAY;
        is_ramp    = 1'b1;
      end
      PH_DECAY: begin
        cur_len    = decay_samples;
        from_level = peak;
        to_level   = sus;
        end_phase  = PH_SUSTAIN;
        is_ramp    = 1'b1;
      end
      PH_RELEASE: begin
        cur_len    = release_samples;
        from_level = release_origin;
        to_level   = '0;
        end_phase  = PH_OFF;
        is_ramp    = 1'b1;
      end
      default: begin
        is_ramp = 1'b0;
      end
    endcase
  end

  assign past_end = elapsed_count > {1'b0, cur_len};

  // Steer the shared multiplier
  always_comb begin
    unique case (state)
      S_MUL_A: begin
        mul_a = $signed(MA_W'(cur_len - elapsed_t));
        mul_b = from_level;
      end
      S_MUL_B: begin
        mul_a = $signed(MA_W'(elapsed_t));
        mul_b = to_level;
      end
      S_MUL_L: begin
        mul_a = MA_W'(left_smp);
        mul_b = level_reg;
      end
      default: begin
        mul_a = MA_W'(right_smp);
        mul_b = level_reg;
      end
    endcase
  end

  assign prod   = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
  assign scaled = prod[SAMPLE_BITS+14:15];

  // Sum of both interpolation terms, then one restoring divide step
  assign acc_sum    = acc + prod[ACC_W-1:0];
  assign trial      = {rem, quo[LEVEL_BITS-1]};
  assign trial_diff = trial - {1'b0, cur_len};
  assign trial_ge   = trial >= {1'b0, cur_len};
  assign quo_next   = {quo[LEVEL_BITS-2:0], trial_ge};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_samples  <= TIME_BITS'(ATTACK_SAMPLES_RST);
      attack_peak     <= ATTACK_PEAK_RST;
      decay_samples   <= TIME_BITS'(DECAY_SAMPLES_RST);
      sustain_level   <= SUSTAIN_LEVEL_RST;
      release_samples <= TIME_BITS'(RELEASE_SAMPLES_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ATTACK_SAMPLES:  attack_samples  <= cfg_data[TIME_BITS-1:0];
        REG_ATTACK_PEAK:     attack_peak     <= cfg_data[LEVEL_BITS-1:0];
        REG_DECAY_SAMPLES:   decay_samples   <= cfg_data[TIME_BITS-1:0];
        REG_SUSTAIN_LEVEL:   sustain_level   <= cfg_data[LEVEL_BITS-1:0];
        REG_RELEASE_SAMPLES: release_samples <= cfg_data[TIME_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      phase_reg      <= PH_OFF;
      elapsed_count  <= '0;
      level_reg      <= '0;
      attack_origin  <= '0;
      release_origin <= '0;
      out_valid      <= 1'b0;
    end else begin
      // Drop the result once it is taken, unless a new one lands now
      if (out_valid && !out_stall && state != S_MUL_R) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            // Restart attack on a rising gate, start release on a falling one
            if ((phase_reg == PH_OFF || phase_reg == PH_RELEASE) && in_data.gate) begin
              phase_reg     <= PH_ATTACK;
              attack_origin <= level_reg;
              elapsed_count <= '0;
            end else if (phase_reg != PH_OFF && phase_reg != PH_RELEASE &&
                         !in_data.gate) begin
              phase_reg      <= PH_RELEASE;
              release_origin <= level_reg;
              elapsed_count  <= '0;
            end
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          priority if (!is_ramp) begin
            state <= S_MUL_L;
          end else if (past_end) begin
            // Advance to the next phase and keep the level, except that the end of release clears it
            phase_reg     <= end_phase;
            elapsed_count <= '0;
            if (phase_reg == PH_RELEASE) begin
              level_reg <= '0;
            end
            state <= S_MUL_L;
          end else if (cur_len == '0) begin
            level_reg <= to_level;
            state     <= S_MUL_L;
          end else begin
            state <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          acc   <= prod[ACC_W-1:0];
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          // Quotient fits 16 bits, so the high part starts below the divisor
          rem     <= acc_sum[ACC_W-1:LEVEL_BITS];
          quo     <= acc_sum[LEVEL_BITS-1:0];
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
          quo     <= quo_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == '1) begin
            level_reg <= quo_next;
            state     <= S_MUL_L;
          end
        end
        S_MUL_L: begin
          left_res <= scaled;
          if (elapsed_count != '1) begin
            elapsed_count <= elapsed_count + 1'b1;
          end
          state <= S_MUL_R;
        end
        S_MUL_R: begin
          // Hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_data.left_out       <= left_res;
            out_data.right_out      <= scaled;
            out_data.envelope_level <= level_reg;
            out_data.phase          <= phase_reg;
            out_valid               <= 1'b1;
            state                   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the sample pair of an accepted beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      left_smp  <= in_data.left_in;
      right_smp <= in_data.right_in;
    end
  end

  `ADSR_ASSERT_ALWAYS(a_level_unity, level_reg <= UNITY, "envelope level above unity")
  `ADSR_ASSERT_ALWAYS(a_phase_code, phase_reg <= PH_RELEASE, "invalid phase code")
  `ADSR_ASSERT_SAME(a_div_rem, state == S_DIV, rem < cur_len, "divider remainder too large")
  `ADSR_ASSERT_NEXT(a_accept_eval, in_accept, state == S_EVAL, "accepted beat not evaluated")

endmodule

`default_nettype wire

### test/tb_linear_adsr_envelope_vca_core.sv
`default_nettype none

module tb_linear_adsr_envelope_vca_core;
  import adsr_pkg::*;

  localparam int TB = TIME_BITS_DEF;
  localparam int CFG_W = (TB > LEVEL_BITS) ? TB : LEVEL_BITS;
  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 40;
  localparam int BEATS_PER_SETTING = 160;
  localparam int SETTINGS_COUNT = 10;
  localparam logic [TB:0] ELAPSED_TOP = '1;
  localparam logic [TB-1:0] LEN_MAX = '1;
  localparam logic [REG_IDX_BITS-1:0] REG_UNUSED_FIRST = REG_RELEASE_SAMPLES + 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  linear_adsr_envelope_vca_core #(.TIME_BITS(TB)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Envelope settings as the block should hold them
  logic [TB-1:0] atk_len = TB'(ATTACK_SAMPLES_RST);
  logic [TB-1:0] dec_len = TB'(DECAY_SAMPLES_RST);
  logic [TB-1:0] rel_len = TB'(RELEASE_SAMPLES_RST);
  logic [15:0] peak_reg = ATTACK_PEAK_RST;
  logic [15:0] sus_reg = SUSTAIN_LEVEL_RST;

  // Envelope state tracked beat by beat
  logic [2:0] env_phase = PH_OFF;
  logic [TB:0] env_elapsed = '0;
  logic [15:0] env_level = '0;
  logic [15:0] atk_from = '0;
  logic [15:0] rel_from = '0;

  in_beat_t pending_beats[$];
  out_beat_t expected_beats[$];

  bit in_taken = 1'b0;
  bit calm = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int cycle_count = 0;
  int errors = 0;

  // Linear interpolation, floor((from*(len-e) + to*e) / len)
  function automatic logic [15:0] ramp(logic [15:0] from, logic [15:0] to,
                                       logic [TB:0] e, logic [TB-1:0] len);
    longint unsigned f, t, ee, ll;
    f = from;
    t = to;
    ee = e;
    ll = len;
    return 16'((f * (ll - ee) + t * ee) / ll);
  endfunction

  // Scale one sample by the level, floor of the product over unity
  function automatic logic signed [15:0] vca(logic signed [15:0] s, logic [15:0] lvl);
    longint p;
    p = longint'(s) * longint'(lvl);
    return 16'(p >>> 15);
  endfunction

  // Advance the envelope by one beat and form the result beat
  function automatic out_beat_t advance_envelope(in_beat_t b);
    logic [15:0] pk, sus;
    logic [TB:0] e;
    out_beat_t r;
    pk = (peak_reg > UNITY) ? UNITY : peak_reg;
    sus = (sus_reg > UNITY) ? UNITY : sus_reg;
    e = env_elapsed;
    if ((env_phase == PH_OFF || env_phase == PH_RELEASE) && b.gate) begin
      env_phase = PH_ATTACK;
      atk_from = env_level;
      e = '0;
    end else if (env_phase != PH_OFF && env_phase != PH_RELEASE && !b.gate) begin
      env_phase = PH_RELEASE;
      rel_from = env_level;
      e = '0;
    end
    case (env_phase)
      PH_ATTACK: begin
        if (e <= atk_len) begin
          env_level = (atk_len == 0) ? pk : ramp(atk_from, pk, e, atk_len);
        end else begin
          env_phase = PH_DECAY;
          e = '0;
        end
      end
      PH_DECAY: begin
        if (e <= dec_len) begin
          env_level = (dec_len == 0) ? sus : ramp(pk, sus, e, dec_len);
        end else begin
          env_phase = PH_SUSTAIN;
          e = '0;
        end
      end
      PH_RELEASE: begin
        if (e <= rel_len) begin
          env_level = (rel_len == 0) ? 16'd0 : ramp(rel_from, 16'd0, e, rel_len);
        end else begin
          env_phase = PH_OFF;
          env_level = '0;
          e = '0;
        end
      end
      default: ;
    endcase
    if (e != ELAPSED_TOP) e = e + 1'b1;
    env_elapsed = e;
    r.left_out = vca(b.left_in, env_level);
    r.right_out = vca(b.right_in, env_level);
    r.envelope_level = env_level;
    r.phase = env_phase;
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic signed [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 19);
    case (r)
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return CFG_W'($urandom_range(0, int'(LEN_MAX)));
      2: return CFG_W'(LEN_MAX);
      default: return CFG_W'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_level();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return CFG_W'(UNITY);
      2: return CFG_W'($urandom);
      3: return CFG_W'($urandom_range(32769, 65535));
      default: return CFG_W'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic add_beat(logic signed [15:0] l, logic signed [15:0] r, logic g);
    in_beat_t b;
    b.left_in = l;
    b.right_in = r;
    b.gate = g;
    pending_beats.push_back(b);
  endtask

  // Wait until every beat is sent and answered, then let the block go quiet
  task automatic settle();
    while (pending_beats.size() != 0 || in_valid || expected_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Drive one register write and mirror it into the predictor
  task automatic set_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_ATTACK_SAMPLES:  atk_len = value[TB-1:0];
      REG_ATTACK_PEAK:     peak_reg = value[15:0];
      REG_DECAY_SAMPLES:   dec_len = value[TB-1:0];
      REG_SUSTAIN_LEVEL:   sus_reg = value[15:0];
      REG_RELEASE_SAMPLES: rel_len = value[TB-1:0];
      default: ;
    endcase
  endtask

  task automatic program_envelope(logic [CFG_W-1:0] a, logic [CFG_W-1:0] p,
                                  logic [CFG_W-1:0] d, logic [CFG_W-1:0] s,
                                  logic [CFG_W-1:0] r);
    set_reg(REG_ATTACK_SAMPLES, a);
    set_reg(REG_ATTACK_PEAK, p);
    set_reg(REG_DECAY_SAMPLES, d);
    set_reg(REG_SUSTAIN_LEVEL, s);
    set_reg(REG_RELEASE_SAMPLES, r);
    // Unmapped index must leave every register alone
    set_reg(REG_UNUSED_FIRST + REG_IDX_BITS'($urandom_range(0, 2)), CFG_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input driver: hold a beat until taken, then gap or send the next
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          in_data <= pending_beats.pop_front();
          in_valid <= 1'b1;
          in_gap = calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left = (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
      end
    end
  end

  // Monitor: check result beats, then predict for accepted input beats
  always @(posedge clk) begin
    out_beat_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with nothing expected: %p", $time, out_data);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          if (out_data.left_out !== want.left_out) begin
            $display("%0t: left_out expected %0d, got %0d",
                     $time, want.left_out, out_data.left_out);
            errors++;
          end
          if (out_data.right_out !== want.right_out) begin
            $display("%0t: right_out expected %0d, got %0d",
                     $time, want.right_out, out_data.right_out);
            errors++;
          end
          if (out_data.envelope_level !== want.envelope_level) begin
            $display("%0t: envelope_level expected %0d, got %0d",
                     $time, want.envelope_level, out_data.envelope_level);
            errors++;
          end
          if (out_data.phase !== want.phase) begin
            $display("%0t: phase expected %0d, got %0d",
                     $time, want.phase, out_data.phase);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_beats.push_back(advance_envelope(in_data));
        in_taken = 1'b1;
      end
    end
  end

  // Stimulus: directed beats, then gated note sequences under many settings
  initial begin
    int n, hold, rest, k;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: silence in off, start an attack, release early
    add_beat(16'sh7fff, 16'sh8000, 1'b0);
    add_beat(16'sh0000, 16'shffff, 1'b1);
    add_beat(16'sh8000, 16'sh7fff, 1'b1);
    add_beat(16'sh3039, -16'sh3039, 1'b0);
    add_beat(16'shffff, 16'sh0001, 1'b0);
    settle();

    // Zero-length phases, levels above unity
    program_envelope('0, CFG_W'(16'hffff), '0, '1, '0);
    add_beat(16'sh7fff, 16'sh8000, 1'b1);
    add_beat(16'sh8000, 16'sh7fff, 1'b1);
    add_beat(16'sh7fff, 16'shffff, 1'b1);
    add_beat(16'sh8000, 16'sh0001, 1'b1);
    add_beat(rand_sample(), rand_sample(), 1'b1);
    add_beat(16'sh7fff, 16'sh8000, 1'b0);
    add_beat(rand_sample(), rand_sample(), 1'b0);
    add_beat(rand_sample(), rand_sample(), 1'b0);
    settle();

    // Short ramps: release mid-decay, retrigger from a partial level
    program_envelope(CFG_W'(3), CFG_W'(20000), CFG_W'(2), CFG_W'(5000), CFG_W'(3));
    for (k = 0; k < 5; k++) add_beat(rand_sample(), rand_sample(), 1'b1);
    for (k = 0; k < 2; k++) add_beat(rand_sample(), rand_sample(), 1'b0);
    for (k = 0; k < 2; k++) add_beat(rand_sample(), rand_sample(), 1'b1);
    for (k = 0; k < 4; k++) add_beat(rand_sample(), rand_sample(), 1'b0);
    settle();

    for (int p = 0; p < SETTINGS_COUNT; p++) begin
      if (p == 0) begin
        program_envelope(CFG_W'(LEN_MAX), CFG_W'(16'hffff), CFG_W'(LEN_MAX),
                         CFG_W'(UNITY), CFG_W'(LEN_MAX));
      end else if (p == 1) begin
        program_envelope('0, '0, '0, '0, '0);
      end else begin
        program_envelope(rand_len(), rand_level(), rand_len(), rand_level(), rand_len());
      end
      calm = (p % 4 == 2);
      n = 0;
      while (n < BEATS_PER_SETTING) begin
        if ($urandom_range(0, 9) < 8) begin
          // Well-formed note: hold the gate, then let it go
          hold = $urandom_range(1, 60);
          rest = $urandom_range(1, 50);
          for (k = 0; k < hold; k++) add_beat(rand_sample(), rand_sample(), 1'b1);
          for (k = 0; k < rest; k++) add_beat(rand_sample(), rand_sample(), 1'b0);
          n += hold + rest;
        end else begin
          // Gate chatter
          hold = $urandom_range(1, 8);
          for (k = 0; k < hold; k++)
            add_beat(rand_sample(), rand_sample(), 1'($urandom_range(0, 1)));
          n += hold;
        end
      end
      settle();
    end

    calm = 1'b0;
    if (errors == 0 && expected_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### linear_adsr_envelope_vca_core.f
+incdir+sv
sv/adsr_pkg.sv
sv/linear_adsr_envelope_vca_core.sv
test/tb_linear_adsr_envelope_vca_core.sv
